FILE: hw/rtl/dnsle_pkg.sv
// Shared types, constants and helpers for the DNS question-section encoder.
package dnsle_pkg;

    localparam int DEF_MAX_LABEL_LEN = 63;
    localparam int DEF_MAX_NAME_LEN  = 255;

    localparam int LABEL_DEPTH = 64;
    localparam int LABEL_AW    = 6;

    localparam logic       CMD_CHAR = 1'b0;
    localparam logic       CMD_END  = 1'b1;
    localparam logic [7:0] DOT_CHAR = 8'd46;

    localparam logic [8:0] EMIT_SAT = 9'h1FF;

    // Bytes after the name: root label, QTYPE A, QCLASS IN.
    localparam int         TAIL_LEN  = 5;
    localparam logic [2:0] TAIL_LAST = 3'(TAIL_LEN - 1);

    localparam int TDATA_W = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_TAIL,
        ST_ERR
    } enc_state_t;

    function automatic logic [7:0] tail_byte(input logic [2:0] step);
        logic [7:0] b;
        b = 8'd0;
        unique case (step)
            3'd2, 3'd4: b = 8'd1;
            default:    b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: hw/rtl/dns_name_label_encoder_unit.sv
// Top level of the DNS question-section encoder: label buffer, sequencer and output register.
//
// Usage: a dotted domain name enters on the s_axis channel, one character per transfer
// (s_axis_tuser = 0) followed by an end-of-name transfer (s_axis_tuser = 1). The encoded
// question section (length-prefixed labels, the root byte, then QTYPE A and QCLASS IN)
// leaves on the m_axis channel, one byte per transfer; m_axis_tlast marks the final byte,
// which also carries the total question length. A bad name yields a single result with
// the error flag set in m_axis_tuser.
//
// An ordinary character is stored in the label buffer (or marks an overflow). A '.' closing
// a label occupies the sequencer while its length byte and data bytes go out, replaying the
// label from a 64 x 8 synchronous RAM with a registered read port; the first data byte is
// prefetched while the length byte goes out. An end item sends the five trailer bytes (a
// single error result on error). Input is refused while a label, the trailer or an error
// result is being sent.
//
// Reset (aresetn low, synchronous) empties the output register and clears the
// label count, overflow flag and byte count; the RAM contents are not cleared.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits; characters are still taken while idle.
module dns_name_label_encoder_unit
    import dnsle_pkg::*;
#(
    parameter int MAX_LABEL_LEN = DEF_MAX_LABEL_LEN,
    parameter int MAX_NAME_LEN  = DEF_MAX_NAME_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] char_byte
    input  logic                 s_axis_tuser,   // [0] cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [7:0] out_byte, [16:8] total_len
    output logic                 m_axis_tlast,   // last
    output logic                 m_axis_tuser    // [0] error
);

    localparam logic [LABEL_AW-1:0] MaxLabel = LABEL_AW'(MAX_LABEL_LEN);
    localparam logic [8:0]          MaxName  = 9'(MAX_NAME_LEN);

    // Label buffer.
    logic [7:0] label_mem [LABEL_DEPTH];
    logic [7:0] rd_data_reg;
    logic [LABEL_AW-1:0] rd_addr;
    logic                wr_en;

    enc_state_t state_reg, state_next;
    logic [LABEL_AW-1:0] count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [8:0]          emit_reg, emit_next;
    logic [LABEL_AW-1:0] idx_reg, idx_next;
    logic [2:0]          step_reg, step_next;
    logic [8:0]          qlen_reg, qlen_next;

    // Output register.
    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_last_reg;
    logic       m_err_reg;
    logic [8:0] m_qlen_reg;

    logic       slot_free;
    logic       load;
    logic [7:0] o_byte;
    logic       o_last;
    logic       o_err;
    logic [8:0] o_qlen;
    logic [9:0] emit_sum;
    logic       end_bad;

    assign slot_free = !m_valid_reg || m_axis_tready;

    // Name bytes after this label closes: length byte plus the label itself.
    assign emit_sum = {1'b0, emit_reg} + {4'b0, count_reg} + 10'd1;
    assign end_bad  = (count_reg != '0) || ovf_reg || (emit_reg >= MaxName);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        emit_next     = emit_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        qlen_next     = qlen_reg;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        s_axis_tready = 1'b0;
        load          = 1'b0;
        o_byte        = 8'd0;
        o_last        = 1'b0;
        o_err         = 1'b0;
        o_qlen        = 9'd0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == CMD_END) begin
                        if (end_bad) begin
                            state_next = ST_ERR;
                        end else begin
                            qlen_next  = 9'(emit_reg + 9'd5);
                            step_next  = 3'd0;
                            state_next = ST_TAIL;
                        end
                        count_next = '0;
                        ovf_next   = 1'b0;
                        emit_next  = 9'd0;
                    end else if (s_axis_tdata == DOT_CHAR) begin
                        if (ovf_reg) begin
                            // An overlong label is dropped without output.
                            count_next = '0;
                        end else begin
                            emit_next  = (emit_sum > {1'b0, EMIT_SAT}) ? EMIT_SAT
                                                                       : emit_sum[8:0];
                            state_next = ST_LEN;
                        end
                    end else if (count_reg >= MaxLabel) begin
                        ovf_next = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_LEN: begin
                rd_addr = '0;
                if (slot_free) begin
                    load     = 1'b1;
                    o_byte   = {{(8 - LABEL_AW){1'b0}}, count_reg};
                    idx_next = '0;
                    if (count_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (slot_free) begin
                    load     = 1'b1;
                    o_byte   = rd_data_reg;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == count_reg - 1'b1) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (slot_free) begin
                    load   = 1'b1;
                    o_byte = tail_byte(step_reg);
                    if (step_reg == TAIL_LAST) begin
                        o_last     = 1'b1;
                        o_qlen     = qlen_reg;
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    load       = 1'b1;
                    o_last     = 1'b1;
                    o_err      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            emit_reg  <= 9'd0;
            idx_reg   <= '0;
            step_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            emit_reg  <= emit_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        qlen_reg <= qlen_next;
    end

    // Label RAM: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            label_mem[count_reg] <= s_axis_tdata;
        end
        rd_data_reg <= label_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_byte_reg <= o_byte;
            m_last_reg <= o_last;
            m_err_reg  <= o_err;
            m_qlen_reg <= o_qlen;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W - 17){1'b0}}, m_qlen_reg, m_byte_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_err_reg;

endmodule

FILE: hw/rtl/dnsle_checker.sv
// Port-level assertions for the DNS question-section encoder, bound to the top level.
module dnsle_checker
    import dnsle_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast,
    input logic               m_axis_tuser
);

    // An error result always closes the question.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("error result without tlast");

    // An error result carries no byte and no length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error result with non-zero data");

    // The question length only appears on the final byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[16:8] == 9'd0)
        else $error("question length on a non-final byte");

    // A good final byte reports at least the five trailer bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> m_axis_tdata[16:8] >= 9'd5)
        else $error("question length too short");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind dns_name_label_encoder_unit dnsle_checker u_dnsle_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
